FILE: design/gsss_pkg.sv
// Shared constants for the generational sparse set store.
// Command and status codes, field widths and parameter defaults; no dependencies.
`timescale 1ns / 1ps

package gsss_pkg;

    localparam int MAX_ENTITIES_DEF = 1024;
    localparam int NUM_TYPES_DEF    = 32;
    localparam int GEN_BITS_DEF     = 16;

    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;
    localparam int TYPE_W = 5;

    localparam logic [CMD_W-1:0] CMD_CREATE  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DESTROY = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_ADD     = 3'd3;
    localparam logic [CMD_W-1:0] CMD_GET     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd5;

    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_INVALID = 3'd1;
    localparam logic [STAT_W-1:0] STAT_ABSENT  = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_PRESENT = 3'd4;

endpackage

FILE: design/gsss_ram.sv
// Simple dual-port synchronous RAM: one write port, one registered read port.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module gsss_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read-before-write on a same-address collision
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

FILE: design/generational_sparse_set_store.sv
// Generational handle allocator with one sparse set per component type.
// Check, get, add and fresh create answer from ST_EXEC; create from the free stack
// adds ST_CRT_POP, and remove adds ST_RM_MOVE when a slot moves. Each update follows
// a registered read of the state memories; ST_EXEC waits while the output register
// is busy, and s_ready stays low until the item's result is registered.
// Destroy walks every type through ST_DS_READ and ST_DS_CHECK, plus ST_DS_MOVE where
// a slot moves, then ends in ST_DS_FINAL. Reset: synchronous; the sparse map is then
// swept clear, 2**(type bits + index bits) entries (32768 by default); s_ready stays low.
`timescale 1ns / 1ps

module generational_sparse_set_store
    import gsss_pkg::*;
#(
    parameter int MAX_ENTITIES = MAX_ENTITIES_DEF,
    parameter int NUM_TYPES    = NUM_TYPES_DEF,
    parameter int GEN_BITS     = GEN_BITS_DEF,
    localparam int IDX_W = $clog2(MAX_ENTITIES)
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [IDX_W-1:0]    s_entity_index,
    input  logic [GEN_BITS-1:0] s_entity_generation,
    input  logic [TYPE_W-1:0]   s_component_type,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [STAT_W-1:0]   m_status,
    output logic [IDX_W-1:0]    m_handle_index,
    output logic [GEN_BITS-1:0] m_handle_generation,
    output logic [IDX_W-1:0]    m_dense_slot,
    output logic                m_is_true,
    output logic                m_moved,
    output logic [IDX_W-1:0]    m_move_from,
    output logic [IDX_W-1:0]    m_move_to,
    output logic [TYPE_W-1:0]   m_move_type,
    output logic                m_last
);

    // counters must hold MAX_ENTITIES itself
    localparam int CNT_W = $clog2(MAX_ENTITIES + 1);
    // type number as used for addressing the per-type sets
    localparam int TI_W  = (NUM_TYPES > 1) ? $clog2(NUM_TYPES) : 1;
    localparam int SP_AW = TI_W + IDX_W;
    localparam int SP_DW = IDX_W + 1;       // {valid, slot}

    localparam logic [CNT_W-1:0] MAX_C  = CNT_W'(MAX_ENTITIES);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);
    localparam logic [TI_W-1:0]  LAST_T = TI_W'(NUM_TYPES - 1);

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_EXEC     = 9'b000000100,
        ST_CRT_POP  = 9'b000001000,
        ST_RM_MOVE  = 9'b000010000,
        ST_DS_READ  = 9'b000100000,
        ST_DS_CHECK = 9'b001000000,
        ST_DS_MOVE  = 9'b010000000,
        ST_DS_FINAL = 9'b100000000
    } state_t;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [IDX_W-1:0]    hidx;
        logic [GEN_BITS-1:0] hgen;
        logic [IDX_W-1:0]    slot;
        logic                is_true;
        logic                moved;
        logic [IDX_W-1:0]    from;
        logic [IDX_W-1:0]    to;
        logic [TYPE_W-1:0]   mtype;
        logic                last;
    } res_t;

    state_t state_reg, state_next;

    // captured item
    logic [CMD_W-1:0]    cmd_reg, cmd_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [GEN_BITS-1:0] gin_reg, gin_next;
    logic [TYPE_W-1:0]   type_reg, type_next;

    // allocator state
    logic [CNT_W-1:0]    fc_reg, fc_next;      // free stack depth
    logic [CNT_W-1:0]    nf_reg, nf_next;      // next fresh index

    // work registers
    logic [GEN_BITS-1:0] gcur_reg, gcur_next;
    logic [IDX_W-1:0]    hidx_reg, hidx_next;
    logic [IDX_W-1:0]    slot_reg, slot_next;
    logic [IDX_W-1:0]    lslot_reg, lslot_next;
    logic [TI_W-1:0]     t_reg, t_next;
    logic [SP_AW-1:0]    clr_reg, clr_next;

    logic [CNT_W-1:0]    dcnt_reg [NUM_TYPES];
    logic                dcnt_inc, dcnt_dec;

    res_t                out_reg, out_next;
    logic                m_valid_reg, m_valid_next;
    logic                out_free, emit;
    res_t                res;

    // memory ports
    logic                gen_we;
    logic [IDX_W-1:0]    gen_waddr, gen_raddr;
    logic [GEN_BITS-1:0] gen_wdata, gen_rd;
    logic                fs_we;
    logic [IDX_W-1:0]    fs_waddr, fs_raddr, fs_wdata, fs_rd;
    logic                sp_we;
    logic [SP_AW-1:0]    sp_waddr, sp_raddr;
    logic [SP_DW-1:0]    sp_wdata, sp_rd;
    logic                own_we;
    logic [SP_AW-1:0]    own_waddr, own_raddr;
    logic [IDX_W-1:0]    own_wdata, own_rd;

    logic [TI_W-1:0]     type_ti, sel_ti;
    logic [CNT_W-1:0]    cnt_sel;
    logic [IDX_W-1:0]    last_w;
    logic                hvalid, type_ok, sp_present;
    logic [IDX_W-1:0]    sp_slot;

    gsss_ram #(.DEPTH(MAX_ENTITIES), .WIDTH(GEN_BITS)) u_gen_ram (
        .aclk(aclk), .we(gen_we), .waddr(gen_waddr), .wdata(gen_wdata),
        .raddr(gen_raddr), .rdata(gen_rd)
    );

    gsss_ram #(.DEPTH(MAX_ENTITIES), .WIDTH(IDX_W)) u_free_ram (
        .aclk(aclk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
        .raddr(fs_raddr), .rdata(fs_rd)
    );

    gsss_ram #(.DEPTH(2 ** SP_AW), .WIDTH(SP_DW)) u_sparse_ram (
        .aclk(aclk), .we(sp_we), .waddr(sp_waddr), .wdata(sp_wdata),
        .raddr(sp_raddr), .rdata(sp_rd)
    );

    gsss_ram #(.DEPTH(2 ** SP_AW), .WIDTH(IDX_W)) u_owner_ram (
        .aclk(aclk), .we(own_we), .waddr(own_waddr), .wdata(own_wdata),
        .raddr(own_raddr), .rdata(own_rd)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_ready;

    assign type_ti  = TI_W'(type_reg);
    assign type_ok  = (32'(type_reg) < NUM_TYPES);
    // destroy walks types by counter; everything else uses the item's type
    assign sel_ti   = (state_reg == ST_DS_READ || state_reg == ST_DS_CHECK ||
                       state_reg == ST_DS_MOVE) ? t_reg : type_ti;
    assign cnt_sel  = dcnt_reg[sel_ti];
    assign last_w   = IDX_W'(cnt_sel - ONE_C);

    assign sp_present = sp_rd[IDX_W];
    assign sp_slot    = sp_rd[IDX_W-1:0];

    // index below the fresh mark means its generation entry was written since reset
    assign hvalid = (idx_reg != '0) && (CNT_W'(idx_reg) < nf_reg) && (gen_rd == gin_reg);

    always_comb begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        gin_next     = gin_reg;
        type_next    = type_reg;
        fc_next      = fc_reg;
        nf_next      = nf_reg;
        gcur_next    = gcur_reg;
        hidx_next    = hidx_reg;
        slot_next    = slot_reg;
        lslot_next   = lslot_reg;
        t_next       = t_reg;
        clr_next     = clr_reg;
        dcnt_inc     = 1'b0;
        dcnt_dec     = 1'b0;
        emit         = 1'b0;
        res          = '0;
        res.last     = 1'b1;

        gen_we    = 1'b0;
        gen_waddr = idx_reg;
        gen_wdata = '0;
        gen_raddr = idx_reg;
        fs_we     = 1'b0;
        fs_waddr  = IDX_W'(fc_reg);
        fs_wdata  = idx_reg;
        fs_raddr  = IDX_W'(fc_reg - ONE_C);
        sp_we     = 1'b0;
        sp_waddr  = {sel_ti, idx_reg};
        sp_wdata  = '0;
        sp_raddr  = {t_reg, idx_reg};
        own_we    = 1'b0;
        own_waddr = {sel_ti, slot_reg};
        own_wdata = own_rd;
        own_raddr = {sel_ti, last_w};

        // swap-and-pop tail: last slot's owner takes over the freed slot
        if (state_reg == ST_RM_MOVE || state_reg == ST_DS_MOVE) begin
            own_we    = 1'b1;
            sp_we     = 1'b1;
            sp_waddr  = {sel_ti, own_rd};
            sp_wdata  = {1'b1, slot_reg};
            res.moved = 1'b1;
            res.from  = lslot_reg;
            res.to    = slot_reg;
        end

        case (state_reg)
            ST_CLEAR: begin
                sp_we    = 1'b1;
                sp_waddr = clr_reg;
                clr_next = clr_reg + SP_AW'(1);
                if (&clr_reg) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                gen_raddr = s_entity_index;
                sp_raddr  = {TI_W'(s_component_type), s_entity_index};
                if (s_valid) begin
                    cmd_next   = s_cmd;
                    idx_next   = s_entity_index;
                    gin_next   = s_entity_generation;
                    type_next  = s_component_type;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                // reads held steady while the output register is busy;
                // create looks up the generation of the popped index
                gen_raddr = (cmd_reg == CMD_CREATE) ? fs_rd : idx_reg;
                sp_raddr  = {type_ti, idx_reg};
                if (out_free) begin
                    gcur_next  = gen_rd;
                    state_next = ST_IDLE;
                    emit       = 1'b1;
                    case (cmd_reg)
                        CMD_CREATE: begin
                            if (fc_reg != '0) begin
                                fc_next    = fc_reg - ONE_C;
                                hidx_next  = fs_rd;
                                emit       = 1'b0;
                                state_next = ST_CRT_POP;
                            end else if (nf_reg >= MAX_C) begin
                                res.status = STAT_FULL;
                            end else begin
                                // fresh index starts at generation zero
                                gen_we    = 1'b1;
                                gen_waddr = IDX_W'(nf_reg);
                                nf_next   = nf_reg + ONE_C;
                                res.hidx  = IDX_W'(nf_reg);
                            end
                        end
                        CMD_DESTROY: begin
                            if (!hvalid) begin
                                res.status = STAT_INVALID;
                            end else begin
                                emit       = 1'b0;
                                t_next     = '0;
                                state_next = ST_DS_READ;
                            end
                        end
                        CMD_CHECK: begin
                            res.is_true = hvalid;
                        end
                        CMD_ADD: begin
                            if (!hvalid) begin
                                res.status = STAT_INVALID;
                            end else if (!type_ok) begin
                                res.status = STAT_FULL;
                            end else if (sp_present) begin
                                res.status = STAT_PRESENT;
                                res.slot   = sp_slot;
                            end else if (cnt_sel >= MAX_C) begin
                                res.status = STAT_FULL;
                            end else begin
                                sp_we     = 1'b1;
                                sp_waddr  = {type_ti, idx_reg};
                                sp_wdata  = {1'b1, IDX_W'(cnt_sel)};
                                own_we    = 1'b1;
                                own_waddr = {type_ti, IDX_W'(cnt_sel)};
                                own_wdata = idx_reg;
                                dcnt_inc  = 1'b1;
                                res.slot  = IDX_W'(cnt_sel);
                            end
                        end
                        CMD_GET: begin
                            if (!hvalid) begin
                                res.status = STAT_INVALID;
                            end else if (!type_ok || !sp_present) begin
                                res.status = STAT_ABSENT;
                            end else begin
                                res.is_true = 1'b1;
                                res.slot    = sp_slot;
                            end
                        end
                        CMD_REMOVE: begin
                            if (!hvalid) begin
                                res.status = STAT_INVALID;
                            end else if (!type_ok || !sp_present) begin
                                res.status = STAT_ABSENT;
                            end else begin
                                sp_we    = 1'b1;
                                sp_waddr = {type_ti, idx_reg};
                                dcnt_dec = 1'b1;
                                if (sp_slot != last_w) begin
                                    slot_next  = sp_slot;
                                    lslot_next = last_w;
                                    emit       = 1'b0;
                                    state_next = ST_RM_MOVE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ST_CRT_POP: begin
                emit       = 1'b1;
                res.hidx   = hidx_reg;
                res.hgen   = gen_rd;
                state_next = ST_IDLE;
            end

            ST_RM_MOVE: begin
                emit       = 1'b1;
                res.mtype  = type_reg;
                state_next = ST_IDLE;
            end

            ST_DS_READ: begin
                state_next = ST_DS_CHECK;
            end

            ST_DS_CHECK: begin
                if (out_free) begin
                    if (t_reg == LAST_T) begin
                        state_next = ST_DS_FINAL;
                    end else begin
                        t_next     = t_reg + TI_W'(1);
                        state_next = ST_DS_READ;
                    end
                    if (sp_present) begin
                        sp_we    = 1'b1;
                        dcnt_dec = 1'b1;
                        if (sp_slot != last_w) begin
                            slot_next  = sp_slot;
                            lslot_next = last_w;
                            t_next     = t_reg;
                            state_next = ST_DS_MOVE;
                        end
                    end
                end
            end

            ST_DS_MOVE: begin
                emit      = 1'b1;
                res.mtype = TYPE_W'(t_reg);
                res.last  = 1'b0;
                if (t_reg == LAST_T) begin
                    state_next = ST_DS_FINAL;
                end else begin
                    t_next     = t_reg + TI_W'(1);
                    state_next = ST_DS_READ;
                end
            end

            ST_DS_FINAL: begin
                if (out_free) begin
                    gen_we    = 1'b1;
                    gen_wdata = gcur_reg + GEN_BITS'(1);
                    if (fc_reg < MAX_C) begin
                        fs_we   = 1'b1;
                        fc_next = fc_reg + ONE_C;
                    end
                    emit       = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output register: load on a result, drop on a transfer
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        if (emit) begin
            m_valid_next = 1'b1;
            out_next     = res;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_reg     <= '0;
            fc_reg      <= '0;
            nf_reg      <= ONE_C;
            m_valid_reg <= 1'b0;
            t_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fc_reg      <= fc_next;
            nf_reg      <= nf_next;
            m_valid_reg <= m_valid_next;
            t_reg       <= t_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        idx_reg   <= idx_next;
        gin_reg   <= gin_next;
        type_reg  <= type_next;
        gcur_reg  <= gcur_next;
        hidx_reg  <= hidx_next;
        slot_reg  <= slot_next;
        lslot_reg <= lslot_next;
        out_reg   <= out_next;
    end

    // per-type dense counts
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_TYPES; i++) begin
                dcnt_reg[i] <= '0;
            end
        end else if (dcnt_inc) begin
            dcnt_reg[sel_ti] <= cnt_sel + ONE_C;
        end else if (dcnt_dec) begin
            dcnt_reg[sel_ti] <= cnt_sel - ONE_C;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_status            = out_reg.status;
    assign m_handle_index      = out_reg.hidx;
    assign m_handle_generation = out_reg.hgen;
    assign m_dense_slot        = out_reg.slot;
    assign m_is_true           = out_reg.is_true;
    assign m_moved             = out_reg.moved;
    assign m_move_from         = out_reg.from;
    assign m_move_to           = out_reg.to;
    assign m_move_type         = out_reg.mtype;
    assign m_last              = out_reg.last;

`ifndef SYNTHESIS
    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        emit |-> out_free)
        else $error("result overwritten before transfer");

    // free stack depth stays below the fresh mark, which never passes MAX_ENTITIES
    a_free_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fc_reg < nf_reg) && (nf_reg <= MAX_C))
        else $error("free stack depth out of bounds");

    a_state_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(state_reg))
        else $error("state register not one-hot");

    // no count change outside the update states
    a_cnt_update: assert property (@(posedge aclk) disable iff (!aresetn)
        (dcnt_inc || dcnt_dec) |-> (state_reg == ST_EXEC || state_reg == ST_DS_CHECK))
        else $error("dense count updated in wrong state");
`endif

endmodule
